[sv/prs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prs_pkg;

  // item kinds carried on the input tuser
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_LEVEL  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_AUTO_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_PREF_HOUR     = 2'd1;
  localparam logic [1:0] CFG_AUTO_DURATION = 2'd2;

  // register reset values
  localparam logic [31:0] AUTO_INTERVAL_RST = 32'd86400;
  localparam logic [5:0]  PREF_HOUR_RST     = 6'd19;
  localparam logic [31:0] AUTO_DURATION_RST = 32'd60000;

  // hour preference switched off (-1 in six bits)
  localparam logic [5:0]  PREF_HOUR_OFF = 6'h3f;

  // four hours of slack around the automatic interval
  localparam logic [31:0] GRACE_S = 32'd14400;

  typedef struct packed {
    logic [7:0]  new_level;
    logic [31:0] run_ms;
    logic        force_req;
    logic        wall_synced;
    logic [4:0]  hour_of_day;
    logic [31:0] now_ms;
    logic [31:0] now_s;
    logic [1:0]  kind;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  level_leds;
    logic        level_changed;
    logic        auto_triggered;
    logic [31:0] on_time_ms;
    logic        refused;
    logic        stopped;
    logic        started;
    logic        pump_on;
  } out_item_t;

  typedef struct packed {
    logic        wr;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

[sv/prs_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// one register slice with valid, full rate when the far side takes every beat
module prs_stage #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s_valid,
  output logic                  s_ready,
  input  wire logic [WIDTH-1:0] s_data,
  output logic                  m_valid,
  input  wire logic             m_ready,
  output logic [WIDTH-1:0]      m_data
);

  logic             valid_r;
  logic [WIDTH-1:0] data_r;

  // slot frees up when empty or when the held beat leaves this cycle
  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= s_data;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

`default_nettype wire

[sv/prs_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// pump state, configuration registers and the per-item decision logic
module prs_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire prs_pkg::cfg_wr_t  cfg,
  input  wire prs_pkg::in_item_t item,
  input  wire logic              fire,
  output prs_pkg::out_item_t     res
);

  // configuration
  logic [31:0] auto_interval_r;
  logic [5:0]  pref_hour_r;
  logic [31:0] auto_duration_r;

  // pump state
  logic        running_r,  running_nxt;
  logic        forced_r,   forced_nxt;
  logic [31:0] start_ms_r, start_ms_nxt;
  logic [31:0] end_ms_r,   end_ms_nxt;
  logic [31:0] last_auto_r, last_auto_nxt;
  logic [7:0]  level_r,    level_nxt;

  // run-due evaluation
  logic [31:0] since_auto;
  logic        hour_hit;
  logic        run_due;

  assign since_auto = item.now_s - last_auto_r;
  assign hour_hit   = !pref_hour_r[5] && (pref_hour_r[4:0] == item.hour_of_day);
  assign run_due    = ((since_auto >= auto_interval_r) && hour_hit)
                   || ((since_auto >= (auto_interval_r - prs_pkg::GRACE_S)) && hour_hit)
                   || ((since_auto >= auto_interval_r)
                       && (pref_hour_r == prs_pkg::PREF_HOUR_OFF))
                   || (since_auto >= (auto_interval_r + prs_pkg::GRACE_S));

  // decision for one item: at most one stop, then at most one start
  always_comb begin
    logic        halt;
    logic        start_req;
    logic        blocked;
    logic        auto_eval;
    logic [31:0] dur;
    logic        start_ok;

    halt      = 1'b0;
    start_req = 1'b0;
    blocked   = 1'b0;
    auto_eval = 1'b0;
    dur       = auto_duration_r;
    start_ok  = 1'b0;

    running_nxt   = running_r;
    forced_nxt    = forced_r;
    start_ms_nxt  = start_ms_r;
    end_ms_nxt    = end_ms_r;
    last_auto_nxt = last_auto_r;
    level_nxt     = level_r;
    res           = '0;

    case (item.kind)
      prs_pkg::KIND_TICK: begin
        // dry and unforced, or timed end passed
        halt = running_r && (((level_r == 8'd0) && !forced_r)
               || ((end_ms_r != 32'd0) && (item.now_ms > end_ms_r)));
        // idle after the dry check: look for an automatic run
        auto_eval = !running_r || ((level_r == 8'd0) && !forced_r);
        if (auto_eval && (run_due || item.force_req) && item.wall_synced) begin
          res.auto_triggered = 1'b1;
          if (!((level_r == 8'd0) && !item.force_req)) begin
            last_auto_nxt = item.now_s;
            start_req     = 1'b1;
          end
        end
      end
      prs_pkg::KIND_START: begin
        start_req = 1'b1;
        dur       = item.run_ms;
        blocked   = running_r || ((level_r == 8'd0) && !item.force_req);
      end
      prs_pkg::KIND_STOP: begin
        halt = 1'b1;
      end
      default: begin
        halt = running_r && (item.new_level == 8'd0) && !forced_r;
        res.level_changed = (level_r != item.new_level);
        level_nxt = item.new_level;
      end
    endcase

    // stop
    if (halt) begin
      running_nxt = 1'b0;
      forced_nxt  = 1'b0;
      end_ms_nxt  = 32'd0;
      if (running_r) begin
        res.stopped    = 1'b1;
        res.on_time_ms = item.now_ms - start_ms_r;
      end
    end

    // start
    start_ok    = start_req && !blocked && (dur != 32'd0);
    res.refused = start_req && !start_ok;
    if (start_ok) begin
      running_nxt  = 1'b1;
      forced_nxt   = item.force_req;
      start_ms_nxt = item.now_ms;
      end_ms_nxt   = dur[31] ? 32'd0 : (item.now_ms + dur);
      res.started  = 1'b1;
    end

    res.pump_on    = running_nxt;
    res.level_leds = level_nxt[1:0];
  end

  // configuration writes, index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_interval_r <= prs_pkg::AUTO_INTERVAL_RST;
      pref_hour_r     <= prs_pkg::PREF_HOUR_RST;
      auto_duration_r <= prs_pkg::AUTO_DURATION_RST;
    end else if (cfg.wr) begin
      case (cfg.index)
        prs_pkg::CFG_AUTO_INTERVAL: auto_interval_r <= cfg.data;
        prs_pkg::CFG_PREF_HOUR:     pref_hour_r     <= cfg.data[5:0];
        prs_pkg::CFG_AUTO_DURATION: auto_duration_r <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // state advances with each item that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      forced_r    <= 1'b0;
      start_ms_r  <= 32'd0;
      end_ms_r    <= 32'd0;
      last_auto_r <= 32'd0;
      level_r     <= 8'd0;
    end else if (fire) begin
      running_r   <= running_nxt;
      forced_r    <= forced_nxt;
      start_ms_r  <= start_ms_nxt;
      end_ms_r    <= end_ms_nxt;
      last_auto_r <= last_auto_nxt;
      level_r     <= level_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/pump_run_scheduler_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pump relay controller. Each input beat carries a kind on in_tuser (tick,
// manual start, stop, water-level update) and returns exactly one result beat
// with the relay state and what the item did. Beats pass through an input
// register, one pass of decision logic against the pump state, and a result
// register: one item is taken every cycle, limited only by the result side
// taking beats. The pump state updates in the same cycle an item moves into
// the result register, so back-to-back items see each other's effect.
// Configuration writes are taken at any time on the cfg channel (cfg_ready
// is always high) but should only be issued while no item is in flight. No
// clearing pass is needed after reset.
module pump_run_scheduler_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input beats
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // now_s[31:0], now_ms[63:32], hour_of_day[68:64], wall_synced[69],
  // force_req[70], run_ms[102:71], new_level[110:103], zero pad[111]
  input  wire logic [111:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]   in_tuser,
  // result beats
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pump_on[0], started[1], stopped[2], refused[3], on_time_ms[35:4],
  // auto_triggered[36], level_changed[37], level_leds[39:38]
  output logic [39:0]       out_tdata,
  // configuration writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int unsigned IN_W  = $bits(prs_pkg::in_item_t);
  localparam int unsigned OUT_W = $bits(prs_pkg::out_item_t);

  prs_pkg::in_item_t  in_item;
  prs_pkg::in_item_t  cur_item;
  prs_pkg::out_item_t res;
  prs_pkg::out_item_t out_item;
  prs_pkg::cfg_wr_t   cfg;

  logic             cur_valid;
  logic             res_ready;
  logic [IN_W-1:0]  cur_bits;
  logic [OUT_W-1:0] out_bits;

  // unpack the input beat
  assign in_item.kind        = in_tuser;
  assign in_item.now_s       = in_tdata[31:0];
  assign in_item.now_ms      = in_tdata[63:32];
  assign in_item.hour_of_day = in_tdata[68:64];
  assign in_item.wall_synced = in_tdata[69];
  assign in_item.force_req   = in_tdata[70];
  assign in_item.run_ms      = in_tdata[102:71];
  assign in_item.new_level   = in_tdata[110:103];

  // configuration channel never stalls
  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  prs_stage #(
    .WIDTH (IN_W)
  ) u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_item),
    .m_valid (cur_valid),
    .m_ready (res_ready),
    .m_data  (cur_bits)
  );

  assign cur_item = prs_pkg::in_item_t'(cur_bits);

  prs_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (cur_item),
    .fire  (cur_valid && res_ready),
    .res   (res)
  );

  prs_stage #(
    .WIDTH (OUT_W)
  ) u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (cur_valid),
    .s_ready (res_ready),
    .s_data  (res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_bits)
  );

  // pack the result beat
  assign out_item = prs_pkg::out_item_t'(out_bits);
  assign out_tdata[0]     = out_item.pump_on;
  assign out_tdata[1]     = out_item.started;
  assign out_tdata[2]     = out_item.stopped;
  assign out_tdata[3]     = out_item.refused;
  assign out_tdata[35:4]  = out_item.on_time_ms;
  assign out_tdata[36]    = out_item.auto_triggered;
  assign out_tdata[37]    = out_item.level_changed;
  assign out_tdata[39:38] = out_item.level_leds;

endmodule

`default_nettype wire

[sv/prs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// port-level checks on the result stream
module prs_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata
);

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // at most one start attempt per item, so a beat never both starts and is refused
  a_start_xor_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[1] && out_tdata[3]))
    else $error("start and refuse on the same beat");

  // run time only reported with a stop
  a_on_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> (out_tdata[35:4] == 32'd0))
    else $error("on time without a stop");

  // a start leaves the relay on, a bare stop leaves it off
  a_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[1] || out_tdata[0])
                && (!(out_tdata[2] && !out_tdata[1]) || !out_tdata[0]))
    else $error("relay state disagrees with start or stop");

endmodule

bind pump_run_scheduler_core prs_checker u_prs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[tb/pump_run_scheduler_core_test.sv]
`timescale 1ns / 1ps

module pump_run_scheduler_core_test;

  localparam int DIR_N = 26;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 190;

  // directed step: input fields, then the typed-in result where there is one
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_s;
    logic [31:0] now_ms;
    logic [4:0]  hour;
    logic        synced;
    logic        force_req;
    logic [31:0] run_ms;
    logic [7:0]  level;
    logic        typed;
    logic        w_on;
    logic        w_started;
    logic        w_stopped;
    logic        w_refused;
    logic [31:0] w_on_time;
    logic        w_auto;
    logic        w_lchg;
    logic [1:0]  w_leds;
  } step_row_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [111:0]  in_tdata = '0;
  logic [1:0]    in_tuser = prs_pkg::KIND_TICK;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [39:0]   out_tdata;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = prs_pkg::CFG_AUTO_INTERVAL;
  logic [31:0]   cfg_data = '0;

  pump_run_scheduler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run stops here whatever happens
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // pump state as the controller should hold it
  logic               pump_running = 1'b0;
  logic               pump_forced = 1'b0;
  logic [31:0]        run_start_ms = '0;
  logic [31:0]        run_end_ms = '0;
  logic [31:0]        last_auto_s = '0;
  logic [7:0]         tank_level = '0;
  logic [31:0]        c_interval = prs_pkg::AUTO_INTERVAL_RST;
  logic signed [5:0]  c_pref_hour = prs_pkg::PREF_HOUR_RST;
  logic signed [31:0] c_auto_ms = prs_pkg::AUTO_DURATION_RST;
  prs_pkg::out_item_t res;

  prs_pkg::out_item_t pending_results [$];
  int errs = 0;
  int n_items = 0, n_started = 0, n_stopped = 0, n_auto = 0, n_refused = 0;
  logic calm = 1'b0;

  function automatic void halt_run(input logic [31:0] now_ms);
    if (pump_running) begin
      res.stopped = 1'b1;
      res.on_time_ms = now_ms - run_start_ms;
    end
    pump_forced = 1'b0;
    run_end_ms = '0;
    pump_running = 1'b0;
  endfunction

  function automatic void try_run(input logic signed [31:0] dur, input logic forced,
                                  input logic [31:0] now_ms);
    if (pump_running || dur == 0 || (tank_level == 0 && !forced)) begin
      res.refused = 1'b1;
      return;
    end
    pump_running = 1'b1;
    pump_forced = forced;
    run_start_ms = now_ms;
    // a timed end that wraps to zero means no timed end
    run_end_ms = (dur > 0) ? now_ms + dur : 32'd0;
    res.started = 1'b1;
  endfunction

  function automatic logic run_due(input logic [31:0] now_s, input logic [4:0] hour);
    logic [31:0] d;
    logic hour_hit;
    d = now_s - last_auto_s;
    hour_hit = (c_pref_hour >= 0) && (int'(c_pref_hour) == int'(hour));
    return (d >= c_interval && hour_hit) ||
           (d >= c_interval - prs_pkg::GRACE_S && hour_hit) ||
           (d >= c_interval && c_pref_hour == prs_pkg::PREF_HOUR_OFF) ||
           (d >= c_interval + prs_pkg::GRACE_S);
  endfunction

  // result of one item, updating the pump state
  function automatic prs_pkg::out_item_t pump_next_result(input prs_pkg::in_item_t it);
    res = '0;
    case (it.kind)
      prs_pkg::KIND_TICK: begin
        if (tank_level == 0 && pump_running && !pump_forced)
          halt_run(it.now_ms);
        if (pump_running) begin
          if (it.now_ms > run_end_ms && run_end_ms != 0)
            halt_run(it.now_ms);
        end else if ((run_due(it.now_s, it.hour_of_day) || it.force_req) &&
                     it.wall_synced) begin
          res.auto_triggered = 1'b1;
          if (!(tank_level == 0 && !it.force_req)) begin
            last_auto_s = it.now_s;
            try_run(c_auto_ms, it.force_req, it.now_ms);
          end
        end
      end
      prs_pkg::KIND_START: try_run(it.run_ms, it.force_req, it.now_ms);
      prs_pkg::KIND_STOP: halt_run(it.now_ms);
      prs_pkg::KIND_LEVEL: begin
        if (pump_running && it.new_level == 0 && !pump_forced)
          halt_run(it.now_ms);
        res.level_changed = (tank_level != it.new_level);
        tank_level = it.new_level;
      end
      default: ;
    endcase
    res.pump_on = pump_running;
    res.level_leds = tank_level[1:0];
    return res;
  endfunction

  // send one item beat, then log what it should produce
  task automatic push_item(input prs_pkg::in_item_t it, input logic typed,
                           input prs_pkg::out_item_t want);
    prs_pkg::out_item_t guess;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.kind;
    in_tdata <= {1'b0, it.new_level, it.run_ms, it.force_req, it.wall_synced,
                 it.hour_of_day, it.now_ms, it.now_s};
    do @(posedge clk); while (!in_tready);
    guess = pump_next_result(it);
    if (typed)
      guess = want;
    pending_results.push_back(guess);
    n_items++;
    n_started += guess.started;
    n_stopped += guess.stopped;
    n_auto += guess.auto_triggered;
    n_refused += guess.refused;
  endtask

  // write all three registers once the block has gone quiet
  task automatic set_phase(input logic [31:0] interval, input logic [5:0] pref,
                           input logic [31:0] dur);
    logic [1:0] idx;
    logic [31:0] val;
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin
          idx = prs_pkg::CFG_AUTO_INTERVAL;
          val = interval;
        end
        1: begin
          idx = prs_pkg::CFG_PREF_HOUR;
          val = {{26{pref[5]}}, pref};
        end
        default: begin
          idx = prs_pkg::CFG_AUTO_DURATION;
          val = dur;
        end
      endcase
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        prs_pkg::CFG_AUTO_INTERVAL: c_interval = val;
        prs_pkg::CFG_PREF_HOUR: c_pref_hour = val[5:0];
        prs_pkg::CFG_AUTO_DURATION: c_auto_ms = val;
        default: ;
      endcase
    end
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endfunction

  // result side back-pressure
  always @(negedge clk)
    out_tready <= calm || ($urandom_range(0, 99) >= 19);

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    prs_pkg::out_item_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        errs++;
      end else begin
        want = pending_results.pop_front();
        check_field("pump_on", want.pump_on, got.pump_on);
        check_field("started", want.started, got.started);
        check_field("stopped", want.stopped, got.stopped);
        check_field("refused", want.refused, got.refused);
        check_field("on_time_ms", want.on_time_ms, got.on_time_ms);
        check_field("auto_triggered", want.auto_triggered, got.auto_triggered);
        check_field("level_changed", want.level_changed, got.level_changed);
        check_field("level_leds", want.level_leds, got.level_leds);
      end
    end
  end

  step_row_t steps [DIR_N] = '{
    // stop while idle
    {prs_pkg::KIND_STOP, 32'd0, 32'd5, 5'd0, 1'b0, 1'b0, 32'd0, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    // unforced start with a dry tank
    {prs_pkg::KIND_START, 32'd0, 32'd10, 5'd0, 1'b0, 1'b0, 32'd1000, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0, 1'b0, 2'd0},
    // zero duration
    {prs_pkg::KIND_START, 32'd0, 32'd20, 5'd0, 1'b0, 1'b1, 32'd0, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0, 1'b0, 2'd0},
    // full tank, then the same level again
    {prs_pkg::KIND_LEVEL, 32'd0, 32'd30, 5'd0, 1'b0, 1'b0, 32'd0, 8'd255,
     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1, 2'd3},
    {prs_pkg::KIND_LEVEL, 32'd0, 32'd40, 5'd0, 1'b0, 1'b0, 32'd0, 8'd255,
     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd3},
    // timed manual run, then a start while running
    {prs_pkg::KIND_START, 32'd0, 32'd100, 5'd0, 1'b0, 1'b0, 32'd1000, 8'd0,
     1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd3},
    {prs_pkg::KIND_START, 32'd0, 32'd200, 5'd0, 1'b0, 1'b1, 32'd5, 8'd0,
     1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0, 1'b0, 2'd3},
    // tick right at the end stamp, then just past it
    {prs_pkg::KIND_TICK, 32'd0, 32'd1100, 5'd0, 1'b0, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    {prs_pkg::KIND_TICK, 32'd0, 32'd1101, 5'd0, 1'b0, 1'b0, 32'd0, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'd1001, 1'b0, 1'b0, 2'd3},
    // forced automatic run
    {prs_pkg::KIND_TICK, 32'd50, 32'd2000, 5'd5, 1'b1, 1'b1, 32'd0, 8'd0,
     1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1, 1'b0, 2'd3},
    // tank runs dry under a forced run: keeps going
    {prs_pkg::KIND_LEVEL, 32'd0, 32'd3000, 5'd0, 1'b0, 1'b0, 32'd0, 8'd0,
     1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1, 2'd0},
    {prs_pkg::KIND_TICK, 32'd60, 32'd62001, 5'd5, 1'b1, 1'b0, 32'd0, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'd60001, 1'b0, 1'b0, 2'd0},
    // run until stopped, across the ms counter wrap
    {prs_pkg::KIND_START, 32'd0, 32'hFFFF_FFF0, 5'd0, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'd0,
     1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    {prs_pkg::KIND_TICK, 32'd70, 32'hFFFF_FFFF, 5'd19, 1'b1, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    {prs_pkg::KIND_STOP, 32'd0, 32'h10, 5'd0, 1'b0, 1'b0, 32'd0, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'h20, 1'b0, 1'b0, 2'd0},
    // timed end that wraps to zero, then a dry stop by level update
    {prs_pkg::KIND_LEVEL, 32'd0, 32'd0, 5'd0, 1'b0, 1'b0, 32'd0, 8'd3,
     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1, 2'd3},
    {prs_pkg::KIND_START, 32'd0, 32'h8000_0001, 5'd0, 1'b0, 1'b0, 32'h7FFF_FFFF, 8'd0,
     1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd3},
    {prs_pkg::KIND_TICK, 32'd80, 32'hFFFF_FFFF, 5'd19, 1'b1, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    {prs_pkg::KIND_LEVEL, 32'd0, 32'h8000_0011, 5'd0, 1'b0, 1'b0, 32'd0, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'h10, 1'b0, 1'b1, 2'd0},
    // forced tick with the clock not synced
    {prs_pkg::KIND_TICK, 32'd100, 32'd0, 5'd19, 1'b0, 1'b1, 32'd0, 8'd0,
     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    // run due but tank dry and not forced
    {prs_pkg::KIND_TICK, 32'd100850, 32'd0, 5'd3, 1'b1, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    {prs_pkg::KIND_LEVEL, 32'd0, 32'd0, 5'd0, 1'b0, 1'b0, 32'd0, 8'd2,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    // early window at the preferred hour
    {prs_pkg::KIND_TICK, 32'd72050, 32'd5000, 5'd19, 1'b1, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    {prs_pkg::KIND_STOP, 32'd0, 32'd9000, 5'd0, 1'b0, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    // interval passed at the wrong hour, then interval plus grace
    {prs_pkg::KIND_TICK, 32'd158450, 32'd10000, 5'd18, 1'b1, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0},
    {prs_pkg::KIND_TICK, 32'd172850, 32'd11000, 5'd0, 1'b1, 1'b0, 32'd0, 8'd0,
     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 2'd0}
  };

  initial begin : stimulus
    step_row_t row;
    prs_pkg::in_item_t it;
    prs_pkg::out_item_t want;
    logic [31:0] wall_s, wall_ms, p_interval, p_dur;
    logic [5:0] p_pref;
    int roll, rnd_cnt, w;
    wall_s = 32'd200000;
    wall_ms = 32'd20000;
    rnd_cnt = 0;

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // directed steps at the reset register values
    for (int i = 0; i < DIR_N; i++) begin
      row = steps[i];
      it = '0;
      it.kind = row.kind;
      it.now_s = row.now_s;
      it.now_ms = row.now_ms;
      it.hour_of_day = row.hour;
      it.wall_synced = row.synced;
      it.force_req = row.force_req;
      it.run_ms = row.run_ms;
      it.new_level = row.level;
      want = '0;
      want.pump_on = row.w_on;
      want.started = row.w_started;
      want.stopped = row.w_stopped;
      want.refused = row.w_refused;
      want.on_time_ms = row.w_on_time;
      want.auto_triggered = row.w_auto;
      want.level_changed = row.w_lchg;
      want.level_leds = row.w_leds;
      push_item(it, row.typed, want);
    end

    // random traffic under a series of register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          p_interval = 32'd0;
          p_pref = prs_pkg::PREF_HOUR_OFF;
          p_dur = 32'hFFFF_FFFF;
        end
        1: begin
          p_interval = 32'hFFFF_FFFF;
          p_pref = 6'd23;
          p_dur = 32'h7FFF_FFFF;
        end
        2: begin
          p_interval = 32'd3600;
          p_pref = 6'd0;
          p_dur = 32'd0;
        end
        3: begin
          p_interval = 32'd14000;
          p_pref = 6'h3e;
          p_dur = 32'd5000;
        end
        4: begin
          p_interval = 32'd600;
          p_pref = 6'h20;
          p_dur = 32'd1;
        end
        default: begin
          p_interval = $urandom_range(0, 200000);
          roll = $urandom_range(0, 24);
          p_pref = (roll == 24) ? prs_pkg::PREF_HOUR_OFF : roll[5:0];
          p_dur = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 100000);
        end
      endcase
      set_phase(p_interval, p_pref, p_dur);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        calm = (rnd_cnt >= 400 && rnd_cnt < 560);
        rnd_cnt++;
        roll = $urandom_range(0, 99);
        it = '0;
        wall_s += $urandom_range(0, (c_interval > 200000) ? 40000 : c_interval / 4 + 100);
        wall_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                               : $urandom_range(0, 1500);
        it.now_s = wall_s;
        it.now_ms = wall_ms;
        if (c_pref_hour >= 0 && c_pref_hour <= 23 && $urandom_range(0, 2) == 0)
          it.hour_of_day = c_pref_hour[4:0];
        else
          it.hour_of_day = 5'($urandom_range(0, 23));
        it.wall_synced = ($urandom_range(0, 99) < 85);
        it.force_req = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0, 1: it.run_ms = 32'hFFFF_FFFF;
          2: it.run_ms = 32'd0;
          3, 4: it.run_ms = $urandom_range(0, 32'h7FFF_FFFF);
          default: it.run_ms = $urandom_range(1, 3000);
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: it.new_level = 8'd0;
          4, 5, 6: it.new_level = 8'($urandom_range(1, 3));
          default: it.new_level = 8'($urandom_range(0, 255));
        endcase
        if (roll < 45)
          it.kind = prs_pkg::KIND_TICK;
        else if (roll < 60)
          it.kind = prs_pkg::KIND_START;
        else if (roll < 70)
          it.kind = prs_pkg::KIND_STOP;
        else if (roll < 88)
          it.kind = prs_pkg::KIND_LEVEL;
        else begin
          // noise: any kind with full-range times
          it.kind = 2'($urandom_range(0, 3));
          it.now_s = $urandom;
          it.now_ms = $urandom;
          it.run_ms = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                                                  : $urandom_range(0, 32'h7FFF_FFFF);
          it.new_level = 8'($urandom_range(0, 255));
        end
        push_item(it, 1'b0, '0);
      end
    end
    calm = 1'b0;
    @(negedge clk) in_tvalid <= 1'b0;

    // drain, bounded
    for (w = 0; w < 4000 && pending_results.size() != 0; w++) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errs++;
    end
    repeat (8) @(posedge clk);

    $display("%0d items over %0d register settings, back-pressure on both sides",
             n_items, PHASES + 1);
    $display("pump starts %0d, stops %0d, automatic attempts %0d, refused starts %0d",
             n_started, n_stopped, n_auto, n_refused);
    if (errs == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[pump_run_scheduler_core.f]
sv/prs_pkg.sv
sv/prs_stage.sv
sv/prs_engine.sv
sv/pump_run_scheduler_core.sv
sv/prs_checker.sv
tb/pump_run_scheduler_core_test.sv
